[rtl/dnms_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the directional non-max suppression block.
package dnms_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int DIR_W       = 3;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int LINE_DEPTH  = 1024;
    localparam int ROW_LIMIT   = 4096;
    localparam int LEN_CFG_W   = 11;
    localparam int ROWS_CFG_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TOTAL  = 1'd1;

    localparam logic [DIR_W-1:0] DIR_VERT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_ANTI = 3'd2;
    localparam logic [DIR_W-1:0] DIR_HORZ = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DIAG = 3'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] center;
        logic [SAMPLE_W-1:0] nbr_a;
        logic [SAMPLE_W-1:0] nbr_b;
        logic                check;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
    } qent_t;

endpackage

[rtl/dnms_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered, read-first output.
module dnms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/dnms_front.sv]
`timescale 1ns / 1ps
// Front end: raster position, line buffers, 3x3 window and neighbor selection.
module dnms_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dnms_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           cfg_write,
    input  logic [dnms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dnms_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           q_full,
    output logic                           q_push,
    output dnms_pkg::qent_t                q_wdata
);
    import dnms_pkg::*;

    logic [COL_W-1:0]    len_m1_reg, len_m1_next;
    logic [ROW_W-1:0]    rows_m1_reg, rows_m1_next;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;

    logic                s2_valid_reg;
    logic                s2_emit_reg;
    logic                s2_interior_reg;
    logic [COL_W-1:0]    s2_pc_reg;
    logic [ROW_W-1:0]    s2_pr_reg;
    logic [COL_W-1:0]    s2_addr_reg;
    logic [SAMPLE_W-1:0] s2_sample_reg;

    logic [SAMPLE_W-1:0] win_reg  [3][3];
    logic [SAMPLE_W-1:0] win_next [3][3];
    logic [DIR_W-1:0]    center_dir_reg;

    logic                accept;
    logic                s2_go;
    logic [SAMPLE_W-1:0] in_sample;
    logic [DIR_W-1:0]    in_dir;
    logic [SAMPLE_W-1:0] top_rd, mid_rd;
    logic [DIR_W-1:0]    dir_rd;

    logic                c_zero;
    logic                emit;
    logic [COL_W-1:0]    pc;
    logic [ROW_W-1:0]    pr;
    logic                interior;

    logic [LEN_CFG_W-1:0]  len_v;
    logic [ROWS_CFG_W-1:0] rows_v;

    logic [SAMPLE_W-1:0] sel_a, sel_b;
    logic                sel_ok;

    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_dir    = s_tdata[SAMPLE_W +: DIR_W];

    assign s2_go    = s2_valid_reg && (!s2_emit_reg || !q_full);
    assign s_tready = !s2_valid_reg || s2_go;
    assign accept   = s_tvalid && s_tready;

    // register clamping
    assign len_v  = cfg_data[LEN_CFG_W-1:0];
    assign rows_v = cfg_data[ROWS_CFG_W-1:0];

    always_comb
    begin
        len_m1_next  = len_m1_reg;
        rows_m1_next = rows_m1_reg;
        if (cfg_write && cfg_index == REG_ROW_LENGTH)
        begin
            if (len_v < LEN_CFG_W'(3))
                len_m1_next = COL_W'(2);
            else if (len_v > LEN_CFG_W'(LINE_DEPTH))
                len_m1_next = COL_W'(LINE_DEPTH - 1);
            else
                len_m1_next = COL_W'(len_v - 1'b1);
        end
        if (cfg_write && cfg_index == REG_ROW_TOTAL)
        begin
            if (rows_v < ROWS_CFG_W'(3))
                rows_m1_next = ROW_W'(2);
            else if (rows_v > ROWS_CFG_W'(ROW_LIMIT))
                rows_m1_next = ROW_W'(ROW_LIMIT - 1);
            else
                rows_m1_next = ROW_W'(rows_v - 1'b1);
        end
    end

    // position of the decided pixel, one row and one column behind
    assign c_zero   = (col_reg == '0);
    assign emit     = (row_reg >= ROW_W'(2)) || (row_reg == ROW_W'(1) && !c_zero);
    assign pc       = c_zero ? len_m1_reg : col_reg - 1'b1;
    assign pr       = c_zero ? row_reg - ROW_W'(2) : row_reg - ROW_W'(1);
    assign interior = (pc != '0) && (pc < len_m1_reg) && (pr != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_m1_reg   <= COL_W'(LINE_DEPTH - 1);
            rows_m1_reg  <= ROW_W'(ROW_LIMIT - 1);
            col_reg      <= '0;
            row_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            len_m1_reg  <= len_m1_next;
            rows_m1_reg <= rows_m1_next;
            if (cfg_write)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (col_reg == len_m1_reg)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == rows_m1_reg) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (accept)
                s2_valid_reg <= 1'b1;
            else if (s2_go)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_emit_reg     <= emit;
            s2_interior_reg <= interior;
            s2_pc_reg       <= pc;
            s2_pr_reg       <= pr;
            s2_addr_reg     <= col_reg;
            s2_sample_reg   <= in_sample;
        end
    end

    dnms_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_line0 (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (in_sample),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    // older line is written back when the item leaves the read stage
    dnms_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_line1 (
        .clk   (clk),
        .we    (s2_go),
        .waddr (s2_addr_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (top_rd)
    );

    dnms_ram #(.WIDTH(DIR_W), .DEPTH(LINE_DEPTH)) u_dline (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (in_dir),
        .re    (accept),
        .raddr (col_reg),
        .rdata (dir_rd)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = top_rd;
        win_next[1][2] = mid_rd;
        win_next[2][2] = s2_sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int m = 0; m < 3; m++)
                begin
                    win_reg[k][m] <= '0;
                end
            end
            center_dir_reg <= '0;
        end
        else if (s2_go)
        begin
            win_reg        <= win_next;
            center_dir_reg <= dir_rd;
        end
    end

    always_comb
    begin
        sel_a  = '0;
        sel_b  = '0;
        sel_ok = 1'b1;
        case (center_dir_reg)
            DIR_VERT:
            begin
                sel_a = win_next[0][1];
                sel_b = win_next[2][1];
            end
            DIR_ANTI:
            begin
                sel_a = win_next[0][2];
                sel_b = win_next[2][0];
            end
            DIR_HORZ:
            begin
                sel_a = win_next[1][0];
                sel_b = win_next[1][2];
            end
            DIR_DIAG:
            begin
                sel_a = win_next[0][0];
                sel_b = win_next[2][2];
            end
            default:
            begin
                sel_ok = 1'b0;
            end
        endcase
    end

    assign q_push         = s2_go && s2_emit_reg;
    assign q_wdata.center = win_next[1][1];
    assign q_wdata.nbr_a  = sel_a;
    assign q_wdata.nbr_b  = sel_b;
    assign q_wdata.check  = sel_ok && s2_interior_reg;
    assign q_wdata.col    = s2_pc_reg;
    assign q_wdata.row    = s2_pr_reg;

endmodule

[rtl/dnms_queue.sv]
`timescale 1ns / 1ps
// Short register queue between front end and decision stage.
module dnms_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dnms_pkg::qent_t wdata,
    output logic            full,
    input  logic            pop,
    output logic            nempty,
    output dnms_pkg::qent_t rdata
);
    import dnms_pkg::*;

    qent_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full   = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign nempty = (count_reg != '0);
    assign rdata  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/dnms_back.sv]
`timescale 1ns / 1ps
// Decision stage: peak test across the direction and output register.
module dnms_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_nempty,
    input  dnms_pkg::qent_t                q_rdata,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dnms_pkg::M_TDATA_W-1:0] m_tdata
);
    import dnms_pkg::*;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_kept_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic                peak;

    // at least both neighbors, strictly above one of them
    assign peak = (q_rdata.center >= q_rdata.nbr_a) && (q_rdata.center >= q_rdata.nbr_b)
                  && ((q_rdata.center > q_rdata.nbr_a) || (q_rdata.center > q_rdata.nbr_b));

    assign q_pop = q_nempty && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_pop)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_kept_reg <= (q_rdata.check && peak) ? q_rdata.center : '0;
            out_col_reg  <= q_rdata.col;
            out_row_reg  <= q_rdata.row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - SAMPLE_W - COL_W - ROW_W){1'b0}},
                       out_row_reg, out_col_reg, out_kept_reg};

endmodule

[rtl/directional_nonmax_suppression.sv]
`timescale 1ns / 1ps
// Path from input beat to output beat: line RAM read, queue, output register.
// Throughput: one beat per cycle unless a full queue stalls the input.
// The first row_length+1 beats of a frame give no output; each later beat gives one.
// Reset: async active low; clears position, queue and window, restores 1024 x 4096.
// Line RAMs are not cleared and need no clearing pass.
module directional_nonmax_suppression (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dnms_pkg::S_TDATA_W-1:0]  s_tdata,   // sample[15:0], direction[18:16]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dnms_pkg::M_TDATA_W-1:0]  m_tdata,   // kept_value[15:0], pixel_column[25:16],
                                                       // pixel_row[37:26]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dnms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dnms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dnms_pkg::*;

    logic  q_push, q_full, q_pop, q_nempty;
    qent_t q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    dnms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    dnms_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .nempty (q_nempty),
        .rdata  (q_rdata)
    );

    dnms_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_nempty (q_nempty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nempty)
        else $error("queue pop while empty");

    a_kept_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[15:0] != '0)) |->
            ((m_tdata[25:16] != '0) && (m_tdata[37:26] != '0)))
        else $error("nonzero result on a border pixel");

endmodule

[test/directional_nonmax_suppression_check.sv]
`timescale 1ns / 1ps
// Checker for directional non-max suppression: predicts decided pixels and compares output beats.
module directional_nonmax_suppression_check
    import dnms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
    } decision_t;

    decision_t decisions_q[$];

    logic [SAMPLE_W-1:0]   mag_line [2][LINE_DEPTH];
    logic [DIR_W-1:0]      dir_line [LINE_DEPTH];
    logic [SAMPLE_W-1:0]   win [3][3];
    logic [DIR_W-1:0]      center_dir;
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [LEN_CFG_W-1:0]  row_length;
    logic [ROWS_CFG_W-1:0] row_total;

    function automatic bit is_peak(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] a,
                                   logic [SAMPLE_W-1:0] b);
        return x >= a && x >= b && (x > a || x > b);
    endfunction

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic decide_pixel(input logic [SAMPLE_W-1:0] mag, input logic [DIR_W-1:0] dir);
        int unsigned         len;
        int unsigned         rows;
        int unsigned         c;
        int unsigned         r;
        int unsigned         pc;
        int unsigned         pr;
        logic [SAMPLE_W-1:0] top;
        logic [SAMPLE_W-1:0] mid;
        logic [SAMPLE_W-1:0] x;
        logic [DIR_W-1:0]    dcen;
        bit                  keep;
        decision_t           d;
        len  = clamp_to(row_length, 3, LINE_DEPTH);
        rows = clamp_to(row_total, 3, ROW_LIMIT);
        c    = col_pos;
        r    = row_pos;

        top = mag_line[1][c];
        mid = mag_line[0][c];
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = mag;
        mag_line[1][c] = mid;
        mag_line[0][c] = mag;

        dcen        = center_dir;
        center_dir  = dir_line[c];
        dir_line[c] = dir;

        if (r >= 2 || (r == 1 && c >= 1))
        begin
            if (c == 0)
            begin
                pc = len - 1;
                pr = r - 2;
            end
            else
            begin
                pc = c - 1;
                pr = r - 1;
            end
            keep = 1'b0;
            x    = win[1][1];
            if (pc >= 1 && pc + 2 <= len && pr >= 1)
            begin
                case (dcen)
                    DIR_VERT: keep = is_peak(x, win[0][1], win[2][1]);
                    DIR_ANTI: keep = is_peak(x, win[0][2], win[2][0]);
                    DIR_HORZ: keep = is_peak(x, win[1][0], win[1][2]);
                    DIR_DIAG: keep = is_peak(x, win[0][0], win[2][2]);
                    default:  keep = 1'b0;
                endcase
            end
            d.value = keep ? x : '0;
            d.col   = COL_W'(pc);
            d.row   = ROW_W'(pr);
            decisions_q.push_back(d);
        end

        c++;
        if (c >= len)
        begin
            c = 0;
            r++;
            if (r >= rows)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decision_t got;
        decision_t want;
        if (!rst_n)
        begin
            decisions_q.delete();
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                mag_line[0][i] = '0;
                mag_line[1][i] = '0;
                dir_line[i]    = '0;
            end
            for (int k = 0; k < 9; k++)
                win[k / 3][k % 3] = '0;
            center_dir = '0;
            col_pos    = 0;
            row_pos    = 0;
            row_length = LEN_CFG_W'(LINE_DEPTH);
            row_total  = ROWS_CFG_W'(ROW_LIMIT);
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.value = m_tdata[15:0];
                got.col   = m_tdata[25:16];
                got.row   = m_tdata[37:26];
                if (decisions_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected beat: value %0d col %0d row %0d",
                                 got.value, got.col, got.row);
                    fail_count++;
                end
                else
                begin
                    want = decisions_q.pop_front();
                    if (got != want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp value %0d col %0d row %0d, got value %0d col %0d row %0d",
                                     want.value, want.col, want.row,
                                     got.value, got.col, got.row);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ROW_LENGTH)
                    row_length = cfg_data[LEN_CFG_W-1:0];
                else if (cfg_index == REG_ROW_TOTAL)
                    row_total = cfg_data[ROWS_CFG_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            if (s_tvalid && s_tready)
                decide_pixel(s_tdata[15:0], s_tdata[18:16]);
            pending <= decisions_q.size();
        end
    end

endmodule

[test/directional_nonmax_suppression_tb.sv]
`timescale 1ns / 1ps
// Testbench top for directional non-max suppression: stimulus, stalls and verdict.
module directional_nonmax_suppression_tb;
    import dnms_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;

    // directed frame, 8 x 3: row 1 keeps a peak in each direction, suppresses a tie and a bad code
    localparam logic [0:23][SAMPLE_W-1:0] PROBE_MAG = '{
        16'd0,     16'd50,  16'd7,   16'd200, 16'd301, 16'd9,   16'd1,     16'd65535,
        16'd65535, 16'd100, 16'd200, 16'd300, 16'd300, 16'd300, 16'd65535, 16'd65535,
        16'd0,     16'd99,  16'd0,   16'd1,   16'd2,   16'd3,   16'd4,     16'd12345
    };
    localparam logic [0:23][DIR_W-1:0] PROBE_DIR = '{
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0,
        3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd0, 3'd4, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int burst_left  = 0;
    int cycle_count = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    logic [1:0] stall_tick = '0;

    directional_nonmax_suppression i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    directional_nonmax_suppression_check i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls: always ready, coin flip, one in four, mostly ready
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 200);
        end
        else
            stall_left <= stall_left - 1;
        stall_tick <= stall_tick + 2'd1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_tick == 2'd0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic send_pixel(input logic [SAMPLE_W-1:0] mag, input logic [DIR_W-1:0] dir);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tdata  <= S_TDATA_W'({dir, mag});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_mag();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            7, 8, 9: return SAMPLE_W'($urandom);
            default: return SAMPLE_W'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [DIR_W-1:0] rand_dir();
        if ($urandom_range(0, 9) < 8)
            return DIR_W'($urandom_range(1, 4));
        return DIR_W'($urandom_range(0, 7));
    endfunction

    task automatic run_phase(input bit wr_len, input int len_val, input bit wr_tot,
                             input int tot_val, input int count, input int hold_at);
        if (wr_len)
            write_reg(REG_ROW_LENGTH, CFG_DATA_W'(len_val));
        if (wr_tot)
            write_reg(REG_ROW_TOTAL, CFG_DATA_W'(tot_val));
        cfg_valid <= 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (hold_at != 0 && i == hold_at)
                drain();
            send_pixel(rand_mag(), rand_dir());
        end
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_ROW_LENGTH, CFG_DATA_W'(8));
        write_reg(REG_ROW_TOTAL, CFG_DATA_W'(3));
        cfg_valid <= 1'b0;
        for (int i = 0; i < 24; i++)
            send_pixel(PROBE_MAG[i], PROBE_DIR[i]);
        drain();

        run_phase(1'b1, 3,       1'b1, 3,       80,    0);
        run_phase(1'b1, 0,       1'b1, 5,       60,    0);
        run_phase(1'b0, 0,       1'b1, 2,       90,    0);
        run_phase(1'b1, 16,      1'b1, 8,       200,   100);
        run_phase(1'b1, 1024,    1'b1, 0,       60,    0);
        run_phase(1'b1, 3,       1'b1, 8191,    160,   0);
        run_phase(1'b1, 13'h1FFF, 1'b0, 0,      40,    0);
        run_phase(1'b1, 6,       1'b1, 4096,    200,   0);

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/dnms_pkg.sv
rtl/dnms_ram.sv
rtl/dnms_front.sv
rtl/dnms_queue.sv
rtl/dnms_back.sv
rtl/directional_nonmax_suppression.sv
test/directional_nonmax_suppression_check.sv
test/directional_nonmax_suppression_tb.sv
